[rtl/pps_pkg.sv]
// Shared types and constants for the preemptive priority scheduler.
`default_nettype none

package pps_pkg;

  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 12;
  localparam int NOW_W   = 17;
  localparam int SLOT_W  = 4;

  localparam logic [NOW_W-1:0] NOW_MAX = '1;

  // Item kind codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // One task slot as held in the table memory
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
  } entry_t;

endpackage

`default_nettype wire

[rtl/pps_table.sv]
// Task slot table: synchronous memory with one read port and one write port, plus per-slot busy flags.
`default_nettype none

module pps_table #(
  parameter int SLOTS = 16,
  parameter int SW    = 4
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   rd_en,
  input  wire  [SW-1:0]         rd_addr,
  output pps_pkg::entry_t       rd_entry,
  output logic                  rd_busy,
  input  wire                   wr_en,
  input  wire  [SW-1:0]         wr_addr,
  input  pps_pkg::entry_t       wr_entry,
  output logic [SLOTS-1:0]      busy
);
  import pps_pkg::*;

  entry_t mem [SLOTS];

  // Memory: one read and one write a cycle, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
      rd_busy  <= busy[rd_addr];
    end
  end

  // Busy flags double as valid bits: a slot that is not busy reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (wr_en) begin
      busy[wr_addr] <= (wr_entry.remaining != '0);
    end
  end

endmodule

`default_nettype wire

[rtl/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler top level: slot table, scan sequencer and result register.
`default_nettype none

// A load beat writes one task slot and returns its result from S_LOADOUT
// once the result register is free. A tick beat reads every slot of the
// table in turn, one per cycle, keeping the ready slot with the smallest
// priority number (lowest slot on a tie), then writes back the chosen slot
// in S_COMMIT once the result register is free. One beat is in work at a
// time; the result register lets the next beat be taken while a result waits
// for the consumer. Loads to a slot at or above SLOTS are dropped, and the
// time counter saturates at its maximum.
module preemptive_priority_scheduler #(
  parameter int SLOTS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          kind,
  input  wire  [pps_pkg::SLOT_W-1:0]   slot,
  input  wire  [pps_pkg::PRIO_W-1:0]   task_priority,
  input  wire  [pps_pkg::TIME_W-1:0]   arrival,
  input  wire  [pps_pkg::TIME_W-1:0]   burst,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         ran,
  output logic [pps_pkg::SLOT_W-1:0]   chosen_slot,
  output logic                         finished,
  output logic [pps_pkg::NOW_W-1:0]    finish_tick,
  output logic [pps_pkg::NOW_W-1:0]    waited,
  output logic                         all_done
);
  import pps_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_LOADOUT} state_t;

  state_t            state;
  logic [CW-1:0]     issue_cnt;
  logic              rd_pend;
  logic [SW-1:0]     rd_idx;
  logic              found;
  logic [SW-1:0]     best_idx;
  entry_t            best;
  logic [NOW_W-1:0]  now;

  logic              accept, load_hit, out_free, commit;
  logic              rd_en, rd_busy, cand_ok, better;
  logic [SW-1:0]     rd_addr;
  entry_t            rd_entry;
  logic              wr_en;
  logic [SW-1:0]     wr_addr;
  entry_t            wr_entry;
  logic [SLOTS-1:0]  busy, busy_after;
  logic [TIME_W-1:0] rem_dec;
  logic [NOW_W-1:0]  now_next, used, wait_val;

  pps_table #(.SLOTS(SLOTS), .SW(SW)) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_busy  (rd_busy),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .busy     (busy)
  );

  // Handshake
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign load_hit = accept && (kind == KIND_LOAD) && (32'(slot) < SLOTS);
  assign commit   = (state == S_COMMIT) && out_free;

  // Scan reads, one slot a cycle
  assign rd_en   = (state == S_SCAN) && (32'(issue_cnt) < SLOTS);
  assign rd_addr = issue_cnt[SW-1:0];

  // Running minimum over ready slots; strict compare keeps the lowest slot on a tie
  assign cand_ok = rd_pend && rd_busy && (NOW_W'(rd_entry.arrival) <= now);
  assign better  = cand_ok && (!found || (rd_entry.prio < best.prio));

  // Commit arithmetic
  assign rem_dec  = best.remaining - TIME_W'(1);
  assign now_next = (now == NOW_MAX) ? now : now + NOW_W'(1);
  assign used     = NOW_W'(best.burst) + NOW_W'(best.arrival);
  assign wait_val = (now_next >= used) ? now_next - used : '0;

  // Table write: a load, or write-back of the chosen slot
  always_comb begin
    wr_en   = load_hit || (commit && found);
    wr_addr = load_hit ? SW'(slot) : best_idx;
    if (load_hit) begin
      wr_entry = '{prio: task_priority, arrival: arrival, burst: burst, remaining: burst};
    end else begin
      wr_entry = '{prio: best.prio, arrival: best.arrival, burst: best.burst,
                   remaining: rem_dec};
    end
  end

  // Busy flags as they stand after this cycle's write
  always_comb begin
    busy_after = busy;
    if (wr_en) begin
      busy_after[wr_addr] = (wr_entry.remaining != '0);
    end
  end

  // Sequencer, time counter and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      now       <= '0;
      found     <= 1'b0;
      rd_pend   <= 1'b0;
      issue_cnt <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            issue_cnt <= '0;
            found     <= 1'b0;
            rd_pend   <= 1'b0;
            state     <= (kind == KIND_TICK) ? S_SCAN : S_LOADOUT;
          end
        end
        S_SCAN: begin
          rd_pend <= rd_en;
          rd_idx  <= rd_addr;
          if (rd_en) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
          if (better) begin
            found    <= 1'b1;
            best_idx <= rd_idx;
            best     <= rd_entry;
          end
          if (rd_pend && (rd_idx == SW'(SLOTS - 1))) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            now         <= now_next;
            out_valid   <= 1'b1;
            ran         <= found;
            chosen_slot <= found ? SLOT_W'(best_idx) : '0;
            finished    <= found && (rem_dec == '0);
            finish_tick <= (found && (rem_dec == '0)) ? now_next : '0;
            waited      <= (found && (rem_dec == '0)) ? wait_val : '0;
            all_done    <= ~|busy_after;
            state       <= S_IDLE;
          end
        end
        S_LOADOUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            ran         <= 1'b0;
            chosen_slot <= '0;
            finished    <= 1'b0;
            finish_tick <= '0;
            waited      <= '0;
            all_done    <= ~|busy;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[dv/pps_checker.sv]
// Scoreboard for the priority scheduler: tracks the task table, predicts each outcome, compares.
`timescale 1ns / 100ps

module pps_checker #(
  parameter int SLOTS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  wire                          kind,
  input  wire  [pps_pkg::SLOT_W-1:0]   slot,
  input  wire  [pps_pkg::PRIO_W-1:0]   task_priority,
  input  wire  [pps_pkg::TIME_W-1:0]   arrival,
  input  wire  [pps_pkg::TIME_W-1:0]   burst,
  input  wire                          out_valid,
  input  wire                          out_ready,
  input  wire                          ran,
  input  wire  [pps_pkg::SLOT_W-1:0]   chosen_slot,
  input  wire                          finished,
  input  wire  [pps_pkg::NOW_W-1:0]    finish_tick,
  input  wire  [pps_pkg::NOW_W-1:0]    waited,
  input  wire                          all_done,
  output int                           fail_count,
  output int                           pending,
  output int                           outcomes_seen,
  output int                           finishes_seen,
  output int                           idle_ticks
);

  import pps_pkg::*;

  typedef struct packed {
    logic              ran;
    logic [SLOT_W-1:0] chosen_slot;
    logic              finished;
    logic [NOW_W-1:0]  finish_tick;
    logic [NOW_W-1:0]  waited;
    logic              all_done;
  } outcome_t;

  // Shadow copy of the task table and the time counter
  logic [PRIO_W-1:0] prio_tbl    [SLOTS];
  logic [TIME_W-1:0] arrival_tbl [SLOTS];
  logic [TIME_W-1:0] burst_tbl   [SLOTS];
  logic [TIME_W-1:0] remain_tbl  [SLOTS];
  logic [NOW_W-1:0]  clock_now;

  outcome_t outcome_q [$];
  outcome_t want, got, next_outcome;
  int       mismatches, seen, done_count, idle_count;

  // Apply one beat to the shadow table and work out its outcome
  task automatic predict_schedule(input logic k, input logic [SLOT_W-1:0] s,
                                  input logic [PRIO_W-1:0] p,
                                  input logic [TIME_W-1:0] a,
                                  input logic [TIME_W-1:0] b, output outcome_t res);
    bit               found;
    int               best;
    logic [PRIO_W-1:0] best_prio;
    logic [NOW_W-1:0]  used;
    bit               empty;
    res = '0;
    found = 1'b0;
    best = 0;
    best_prio = '0;
    if (k == KIND_LOAD) begin
      if (int'(s) < SLOTS) begin
        prio_tbl[s]    = p;
        arrival_tbl[s] = a;
        burst_tbl[s]   = b;
        remain_tbl[s]  = b;
      end
    end else begin
      // smallest priority number among arrived slots with work, lowest slot on a tie
      for (int i = 0; i < SLOTS; i++) begin
        if (remain_tbl[i] != '0 && NOW_W'(arrival_tbl[i]) <= clock_now) begin
          if (!found || prio_tbl[i] < best_prio) begin
            found = 1'b1;
            best = i;
            best_prio = prio_tbl[i];
          end
        end
      end
      if (clock_now != NOW_MAX) clock_now = clock_now + 1'b1;
      if (found) begin
        res.ran = 1'b1;
        res.chosen_slot = SLOT_W'(best);
        remain_tbl[best] = remain_tbl[best] - 1'b1;
        if (remain_tbl[best] == '0) begin
          used = NOW_W'(burst_tbl[best]) + NOW_W'(arrival_tbl[best]);
          res.finished = 1'b1;
          res.finish_tick = clock_now;
          res.waited = (clock_now >= used) ? clock_now - used : '0;
          done_count++;
        end
      end else begin
        idle_count++;
      end
    end
    empty = 1'b1;
    for (int i = 0; i < SLOTS; i++) if (remain_tbl[i] != '0) empty = 1'b0;
    res.all_done = empty;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        prio_tbl[i]    = '0;
        arrival_tbl[i] = '0;
        burst_tbl[i]   = '0;
        remain_tbl[i]  = '0;
      end
      clock_now = '0;
      outcome_q.delete();
    end else begin
      // outcome beat against the oldest prediction
      if (out_valid && out_ready) begin
        got = '{ran, chosen_slot, finished, finish_tick, waited, all_done};
        seen++;
        if (outcome_q.size() == 0) begin
          $error("outcome beat with nothing predicted");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          check_field("ran", want.ran, got.ran);
          check_field("chosen_slot", want.chosen_slot, got.chosen_slot);
          check_field("finished", want.finished, got.finished);
          check_field("finish_tick", want.finish_tick, got.finish_tick);
          check_field("waited", want.waited, got.waited);
          check_field("all_done", want.all_done, got.all_done);
        end
      end
      // request beat: update shadow state, queue its outcome
      if (in_valid && in_ready) begin
        predict_schedule(kind, slot, task_priority, arrival, burst, next_outcome);
        outcome_q.push_back(next_outcome);
      end
    end
    pending       <= outcome_q.size();
    fail_count    <= mismatches;
    outcomes_seen <= seen;
    finishes_seen <= done_count;
    idle_ticks    <= idle_count;
  end

  initial begin
    mismatches = 0;
    seen = 0;
    done_count = 0;
    idle_count = 0;
    clock_now = '0;
    pending = 0;
    fail_count = 0;
    outcomes_seen = 0;
    finishes_seen = 0;
    idle_ticks = 0;
  end

endmodule

[dv/testbench.sv]
// Top of the scheduler testbench: clock, reset, request stimulus, output back-pressure, verdict.
`timescale 1ns / 100ps

module testbench;

  import pps_pkg::*;

  localparam int SLOT_COUNT      = 16;
  localparam int PHASE_BEATS     = 275;
  localparam int LONG_STALL_CYC  = 300;
  localparam int SETTLE_CYC      = 40;
  localparam int MAX_ARRIVAL     = 4095;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               kind;
  logic [SLOT_W-1:0]  slot;
  logic [PRIO_W-1:0]  task_priority;
  logic [TIME_W-1:0]  arrival;
  logic [TIME_W-1:0]  burst;
  logic               out_ready;
  logic               in_ready;
  logic               out_valid;
  logic               ran;
  logic [SLOT_W-1:0]  chosen_slot;
  logic               finished;
  logic [NOW_W-1:0]   finish_tick;
  logic [NOW_W-1:0]   waited;
  logic               all_done;

  int fail_count, pending, outcomes_seen, finishes_seen, idle_ticks;
  int send_idle_pct, recv_idle_pct;
  int stall_requests;
  int beats_sent, loads_sent, ticks_sent;

  preemptive_priority_scheduler #(.SLOTS(SLOT_COUNT)) uut (
    .clk, .rst, .in_valid, .in_ready, .kind, .slot, .task_priority, .arrival, .burst,
    .out_valid, .out_ready, .ran, .chosen_slot, .finished, .finish_tick, .waited,
    .all_done
  );

  pps_checker #(.SLOTS(SLOT_COUNT)) chk (
    .clk, .rst, .in_valid, .in_ready, .kind, .slot, .task_priority, .arrival, .burst,
    .out_valid, .out_ready, .ran, .chosen_slot, .finished, .finish_tick, .waited,
    .all_done, .fail_count, .pending, .outcomes_seen, .finishes_seen, .idle_ticks
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Output side: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int served;
    served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_requests != served) begin
        served++;
        out_ready <= 1'b0;
        repeat (LONG_STALL_CYC - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One request beat, with random idle cycles in front of it
  task automatic send_beat(input logic k, input logic [SLOT_W-1:0] s,
                           input logic [PRIO_W-1:0] p, input logic [TIME_W-1:0] a,
                           input logic [TIME_W-1:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    slot          <= s;
    task_priority <= p;
    arrival       <= a;
    burst         <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (k == KIND_TICK) ticks_sent++;
    else loads_sent++;
  endtask

  task automatic send_load(input int s, input int p, input int a, input int b);
    send_beat(KIND_LOAD, SLOT_W'(s), PRIO_W'(p), TIME_W'(a), TIME_W'(b));
  endtask

  // load fields carry junk on a tick; the block must ignore them
  task automatic send_tick();
    send_beat(KIND_TICK, SLOT_W'($urandom), PRIO_W'($urandom), TIME_W'($urandom),
              TIME_W'($urandom));
  endtask

  // arrival from two ticks before to twelve ticks after the current time, clamped to the field range
  function automatic int near_arrival();
    int a;
    a = ticks_sent + $urandom_range(0, 14) - 2;
    if (a < 0) a = 0;
    if (a > MAX_ARRIVAL) a = MAX_ARRIVAL;
    return a;
  endfunction

  // One random episode: mostly a batch of loads followed by a run of ticks
  task automatic run_episode();
    int pick, n;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // noise: arbitrary load, fields over their full range
      send_load($urandom_range(15), $urandom_range(255), $urandom_range(MAX_ARRIVAL),
                $urandom_range(MAX_ARRIVAL));
    end else if (pick < 15) begin
      // empty the whole table
      for (int i = 0; i < SLOT_COUNT; i++) send_load(i, $urandom, $urandom, 0);
    end else if (pick < 22) begin
      // a few slots emptied, some of them possibly busy
      n = $urandom_range(1, 4);
      repeat (n) send_load($urandom_range(15), $urandom, $urandom, 0);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        send_load($urandom_range(15),
                  ($urandom_range(1) != 0) ? $urandom_range(7) : $urandom_range(255),
                  near_arrival(),
                  ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40));
      end
      n = $urandom_range(1, 24);
      repeat (n) send_tick();
    end
  endtask

  // One idling phase, then a pause until every outcome is back
  task automatic run_phase(input int send_pct, input int recv_pct, input bit long_stall);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (long_stall) stall_requests++;
    start = beats_sent;
    while (beats_sent - start < PHASE_BEATS) run_episode();
    in_valid <= 1'b0;
    // the pending count is registered in the checker and lags behind the last beat
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_requests = 0;
    beats_sent = 0;
    loads_sent = 0;
    ticks_sent = 0;
    in_valid      <= 1'b0;
    kind          <= KIND_LOAD;
    slot          <= '0;
    task_priority <= '0;
    arrival       <= '0;
    burst         <= '0;
    rst           <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle ticks, ties, preemption, reload, emptying, field extremes
    send_tick();                        // empty table: idle
    send_load(15, 0, 4095, 4095);       // not yet arrived
    send_tick();                        // idle with work waiting
    send_load(3, 5, 0, 2);
    send_load(1, 5, 2, 1);
    send_tick();                        // tie on priority: slot 1 wins and finishes
    send_load(2, 255, 3, 3);
    send_tick();                        // slot 3
    send_load(4, 0, 4, 1);
    send_tick();                        // slot 4 preempts
    send_load(3, 5, 5, 3);              // reload of a busy slot
    send_tick();
    send_load(3, 5, 0, 0);              // empties slot 3
    repeat (3) send_tick();             // slot 2 runs out, with a wait
    send_load(15, 0, 0, 0);             // table empty again
    send_load(0, 255, 0, 4095);
    send_tick();
    send_load(0, 0, 0, 0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random phases
    run_phase(0, 0, 1'b1);
    run_phase(52, 0, 1'b0);
    run_phase(0, 52, 1'b0);
    run_phase(16, 16, 1'b0);

    repeat (SETTLE_CYC) @(posedge clk);
    $display("Run covered %0d beats (%0d loads, %0d ticks) under four idling patterns",
             beats_sent, loads_sent, ticks_sent);
    $display("and a long output hold-off; %0d outcomes checked, %0d finishes, %0d idle ticks.",
             outcomes_seen, finishes_seen, idle_ticks);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
